// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication does not hold");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- design/lr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS  = 6;
    localparam int CNT_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int COLOR_BITS  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};
    localparam logic [COORD_BITS-1:0] COORD_ONE   = COORD_BITS'(1);
    localparam logic [CNT_BITS-1:0]   CNT_ONE     = CNT_BITS'(1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]   count_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    // One classified segment, ready for the walker.
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        logic   x_major;
        logic   dir_x_neg;
        logic   dir_y_neg;
        err_t   err_init;
        err_t   inc_pos;
        err_t   inc_neg;
        count_t count;
    } lr_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lr_q_stat_t;

    typedef struct packed {
        logic busy;
        logic left_zero;
    } lr_back_stat_t;

    function automatic coord_t step_coord(input coord_t v, input logic neg);
        step_coord = neg ? (v - COORD_ONE) : (v + COORD_ONE);
    endfunction

endpackage

`default_nettype wire

// ----- design/lr_seg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lr_seg_if;
    logic               valid;
    logic               ready;
    lr_pkg::coord_t     start_x;
    lr_pkg::coord_t     start_y;
    lr_pkg::coord_t     end_x;
    lr_pkg::coord_t     end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// ----- design/lr_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lr_pix_if;
    logic                              valid;
    logic                              ready;
    lr_pkg::coord_t                    pixel_x;
    lr_pkg::coord_t                    pixel_y;
    logic [lr_pkg::COLOR_BITS-1:0]     pixel_color;
    logic                              last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

// ----- design/lr_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lr_pkg::COLOR_BITS-1:0] draw_color;

    modport source (output valid, draw_color, input ready);
    modport sink   (input valid, draw_color, output ready);
endinterface

`default_nettype wire

// ----- design/lr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lr_front (
    input  logic            clk,
    input  logic            rst_n,
    lr_seg_if.sink          seg,
    output lr_pkg::lr_cmd_t cmd,
    output logic            cmd_valid,
    input  logic            cmd_ready
);
    import lr_pkg::*;

    lr_cmd_t cmd_reg;
    lr_cmd_t cmd_next;
    logic    cmd_valid_reg;
    logic    cmd_valid_next;
    logic    accept;

    coord_t  dx;
    coord_t  dy;
    coord_t  dmaj;
    coord_t  dmin;
    logic    x_major;

    assign seg.ready = !cmd_valid_reg || cmd_ready;
    assign accept    = seg.valid && seg.ready;
    assign cmd       = cmd_reg;
    assign cmd_valid = cmd_valid_reg;

    always_comb
    begin
        dx      = (seg.start_x >= seg.end_x) ? (seg.start_x - seg.end_x)
                                             : (seg.end_x - seg.start_x);
        dy      = (seg.start_y >= seg.end_y) ? (seg.start_y - seg.end_y)
                                             : (seg.end_y - seg.start_y);
        x_major = (dy <= dx);
        dmaj    = x_major ? dx : dy;
        dmin    = x_major ? dy : dx;

        cmd_next.start_x   = seg.start_x;
        cmd_next.start_y   = seg.start_y;
        cmd_next.x_major   = x_major;
        cmd_next.dir_x_neg = !(seg.start_x < seg.end_x);
        cmd_next.dir_y_neg = !(seg.start_y < seg.end_y);
        cmd_next.inc_pos   = ERR_BITS'({dmin, 1'b0});
        cmd_next.err_init  = ERR_BITS'({dmin, 1'b0}) - ERR_BITS'(dmaj);
        cmd_next.inc_neg   = ERR_BITS'({dmin, 1'b0}) - ERR_BITS'({dmaj, 1'b0});
        cmd_next.count     = CNT_BITS'(dmaj) + CNT_ONE;

        cmd_valid_next = accept ? 1'b1 : (cmd_ready ? 1'b0 : cmd_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/lr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  lr_pkg::lr_cmd_t    push_data,
    input  logic               push,
    input  logic               pop,
    output lr_pkg::lr_cmd_t    head,
    output lr_pkg::lr_q_stat_t stat
);
    import lr_pkg::*;

    localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

    lr_cmd_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_next;
    logic [QCNT_BITS-1:0]  cnt_reg;
    logic [QCNT_BITS-1:0]  cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QPTR_BITS'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + QCNT_BITS'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_BITS'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/lr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lr_pkg::lr_cmd_t               cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  logic [lr_pkg::COLOR_BITS-1:0] color,
    lr_pix_if.source                      pixel,
    output lr_pkg::lr_back_stat_t         stat
);
    import lr_pkg::*;

    logic   busy_reg, busy_next;
    logic   out_valid_reg, out_valid_next;
    coord_t walk_x_reg, walk_x_next;
    coord_t walk_y_reg, walk_y_next;
    err_t   err_reg, err_next;
    err_t   inc_pos_reg, inc_pos_next;
    err_t   inc_neg_reg, inc_neg_next;
    count_t left_reg, left_next;
    logic   x_major_reg, x_major_next;
    logic   dir_x_reg, dir_x_next;
    logic   dir_y_reg, dir_y_next;

    coord_t                  px_x_reg, px_x_next;
    coord_t                  px_y_reg, px_y_next;
    logic [COLOR_BITS-1:0]   px_color_reg, px_color_next;
    logic                    px_last_reg, px_last_next;

    logic   load;
    logic   emit;
    logic   err_pos;
    logic   is_last;

    assign load    = !busy_reg && cmd_valid;
    assign emit    = busy_reg && (!out_valid_reg || pixel.ready);
    assign cmd_pop = load;
    assign err_pos = !err_reg[ERR_BITS-1] && (err_reg != '0);
    assign is_last = (left_reg == CNT_ONE);

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = px_x_reg;
    assign pixel.pixel_y     = px_y_reg;
    assign pixel.pixel_color = px_color_reg;
    assign pixel.last_pixel  = px_last_reg;

    assign stat.busy      = busy_reg;
    assign stat.left_zero = (left_reg == '0);

    always_comb
    begin
        busy_next     = busy_reg;
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        err_next      = err_reg;
        inc_pos_next  = inc_pos_reg;
        inc_neg_next  = inc_neg_reg;
        left_next     = left_reg;
        x_major_next  = x_major_reg;
        dir_x_next    = dir_x_reg;
        dir_y_next    = dir_y_reg;
        px_x_next     = px_x_reg;
        px_y_next     = px_y_reg;
        px_color_next = px_color_reg;
        px_last_next  = px_last_reg;

        out_valid_next = emit ? 1'b1 : (pixel.ready ? 1'b0 : out_valid_reg);

        if (load)
        begin
            busy_next    = 1'b1;
            walk_x_next  = cmd.start_x;
            walk_y_next  = cmd.start_y;
            err_next     = cmd.err_init;
            inc_pos_next = cmd.inc_pos;
            inc_neg_next = cmd.inc_neg;
            left_next    = cmd.count;
            x_major_next = cmd.x_major;
            dir_x_next   = cmd.dir_x_neg;
            dir_y_next   = cmd.dir_y_neg;
        end
        else if (emit)
        begin
            px_x_next     = walk_x_reg;
            px_y_next     = walk_y_reg;
            px_color_next = color;
            px_last_next  = is_last;
            left_next     = left_reg - CNT_ONE;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + (err_pos ? inc_neg_reg : inc_pos_reg);
                if (x_major_reg)
                begin
                    walk_x_next = step_coord(walk_x_reg, dir_x_reg);
                    if (err_pos)
                    begin
                        walk_y_next = step_coord(walk_y_reg, dir_y_reg);
                    end
                end
                else
                begin
                    walk_y_next = step_coord(walk_y_reg, dir_y_reg);
                    if (err_pos)
                    begin
                        walk_x_next = step_coord(walk_x_reg, dir_x_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_x_reg   <= walk_x_next;
        walk_y_reg   <= walk_y_next;
        err_reg      <= err_next;
        inc_pos_reg  <= inc_pos_next;
        inc_neg_reg  <= inc_neg_next;
        x_major_reg  <= x_major_next;
        dir_x_reg    <= dir_x_next;
        dir_y_reg    <= dir_y_next;
        px_x_reg     <= px_x_next;
        px_y_reg     <= px_y_next;
        px_color_reg <= px_color_next;
        px_last_reg  <= px_last_next;
    end

endmodule

`default_nettype wire

// ----- design/line_rasterizer_top.sv -----
// A segment is registered in the front end, written to the queue, loaded by the walker
// and then registered as its first pixel. Throughput: dmajor+1 pixels per segment, one
// per cycle while pixel.ready allows; the walker loads the next segment only after the
// last pixel of this one. The rate is set by the single Bresenham step unit in the walker.
// Reset (rst_n, async, active low) empties the queue and stages; draw_color resets to white.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module line_rasterizer_top (
    input  logic     clk,
    input  logic     rst_n,
    lr_seg_if.sink   seg,
    lr_pix_if.source pixel,
    lr_cfg_if.sink   cfg
);
    import lr_pkg::*;

    logic [COLOR_BITS-1:0] color_reg;
    logic [COLOR_BITS-1:0] color_next;

    lr_cmd_t       front_cmd;
    logic          front_valid;
    logic          q_ready;
    lr_cmd_t       q_head;
    lr_q_stat_t    q_stat;
    logic          q_pop;
    lr_back_stat_t bk_stat;

    assign cfg.ready  = 1'b1;
    assign color_next = (cfg.valid && cfg.ready) ? cfg.draw_color : color_reg;
    assign q_ready    = !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    lr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (q_ready)
    );

    lr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_data (front_cmd),
        .push      (front_valid),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    lr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_head),
        .cmd_valid (!q_stat.empty),
        .cmd_pop   (q_pop),
        .color     (color_reg),
        .pixel     (pixel),
        .stat      (bk_stat)
    );

    `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_stat.empty)
    `ASSERT_IMPLIES(a_busy_has_pixels, clk, rst_n, bk_stat.busy, !bk_stat.left_zero)
    `ASSERT_IMPLIES(a_busy_from_queue, clk, rst_n, $rose(bk_stat.busy), $past(!q_stat.empty))
    `ASSERT_IMPLIES(a_last_ends_walk, clk, rst_n, bk_stat.busy && pixel.valid && pixel.last_pixel && $rose(pixel.valid), $past(bk_stat.busy))

endmodule

`default_nettype wire
